[hdl/mac_pkg.sv]
// ----------------------------------------------------------------------------
// mac_pkg: shared types and constants for the moving-average crossover unit
// Register codes, relation and signal codes, and the command flags that
// travel from the front part to the back part through the command queue.
// ----------------------------------------------------------------------------
package mac_pkg;

  // configuration register file
  localparam int CFG_W  = 9;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CFG_W-1:0] SHORT_RESET = 9'd20;
  localparam logic [CFG_W-1:0] LONG_RESET  = 9'd50;

  typedef enum logic [0:0] {
    REG_SHORT = 1'b0,
    REG_LONG  = 1'b1
  } reg_idx_t;

  // relation of short average to long average
  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_ABOVE = 2'd1,
    REL_BELOW = 2'd2
  } rel_t;

  // result codes
  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_t;

  // per-beat classification made by the front part
  typedef struct packed {
    logic sub_short;  // oldest price leaves the short window
    logic sub_long;   // oldest price leaves the long window
    logic armed;      // previous relation is valid, a cross may be reported
    logic eval;       // relation gets recorded for this beat
  } cmd_flags_t;

  // queue depths
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

endpackage

[hdl/mac_queue.sv]
// ----------------------------------------------------------------------------
// mac_queue: small register FIFO
// Flop-based first-in first-out queue with an occupancy count. The caller
// never pushes when full nor pops when empty.
// ----------------------------------------------------------------------------
module mac_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  assign dout  = entries[rd_ptr];
  assign empty = (count == '0);

endmodule

[hdl/mac_front.sv]
// ----------------------------------------------------------------------------
// mac_front: price intake and ring buffer
// Accepts a price beat, stores it in the history ring, reads the prices that
// leave the short and long windows, classifies the beat against the warm-up
// count and queues a command for the back part in the next cycle.
// ----------------------------------------------------------------------------
module mac_front #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    short_win,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    long_win,
  input  logic                               push,
  input  logic [PRICE_BITS-1:0]              price,
  output logic                               full,
  input  logic [mac_pkg::CMD_CNT_W-1:0]      q_count,
  output logic                               q_push,
  output mac_pkg::cmd_flags_t                q_flags,
  output logic [PRICE_BITS-1:0]              q_price,
  output logic [PRICE_BITS-1:0]              q_old_short,
  output logic [PRICE_BITS-1:0]              q_old_long
);
  import mac_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int PW    = AW + 1;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(MAX_WINDOW + 2);

  logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
  logic [AW-1:0]         wp, wp_next, addr_short, addr_long;
  logic [CNT_W-1:0]      seen, seen_next;
  logic                  accept;
  logic                  f_valid;
  cmd_flags_t            f_flags, flags_next;
  logic [PRICE_BITS-1:0] f_price, rd_short, rd_long;

  // ring slot w beats back from p, modulo the ring depth
  function automatic logic [AW-1:0] back_addr(logic [AW-1:0] p, logic [WIN_W-1:0] w);
    logic [PW-1:0] pe, we, d;
    pe = {1'b0, p};
    we = PW'(w);
    if (pe >= we) begin
      d = pe - we;
    end else begin
      d = pe + PW'(MAX_WINDOW) - we;
    end
    return d[AW-1:0];
  endfunction

  // reserve a slot for the beat still in the read stage
  assign full   = ({1'b0, q_count} + (CMD_CNT_W+1)'(f_valid)) >= (CMD_CNT_W+1)'(CMD_DEPTH);
  assign accept = push && !full;

  // addresses and classification
  always_comb begin
    addr_short = back_addr(wp, short_win);
    addr_long  = back_addr(wp, long_win);
    wp_next    = (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);
    if (seen < CNT_W'(long_win) + CNT_W'(1)) begin
      seen_next = seen + CNT_W'(1);
    end else begin
      seen_next = seen;
    end
    flags_next.sub_short = (seen >= CNT_W'(short_win));
    flags_next.sub_long  = (seen >= CNT_W'(long_win));
    flags_next.armed     = (seen >= CNT_W'(long_win));
    flags_next.eval      = (seen_next >= CNT_W'(long_win));
  end

  // front control state
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wp      <= '0;
      seen    <= '0;
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept;
      if (accept) begin
        wp   <= wp_next;
        seen <= seen_next;
      end
    end
  end

  // beat payload for the read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      f_price <= price;
      f_flags <= flags_next;
    end
  end

  // history ring: read-first, so a full-depth window sees the old entry
  always_ff @(posedge clk) begin
    rd_short <= ring[addr_short];
    rd_long  <= ring[addr_long];
    if (accept) begin
      ring[wp] <= price;
    end
  end

  assign q_push      = f_valid;
  assign q_flags     = f_flags;
  assign q_price     = f_price;
  assign q_old_short = rd_short;
  assign q_old_long  = rd_long;

  // checks
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> (seen == '0 && wp == '0))
    else $error("history not cleared after restart");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    !restart |-> seen <= CNT_W'(long_win) + CNT_W'(1))
    else $error("warm-up count past its limit");

  a_cmd_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_count != CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue overflow");

endmodule

[hdl/mac_back.sv]
// ----------------------------------------------------------------------------
// mac_back: running sums, cross-multiply compare and result queue
// Pops commands, updates both running sums, multiplies each sum by the other
// window, compares the products and reports golden or death crosses.
// ----------------------------------------------------------------------------
module mac_back #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] short_win,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] long_win,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  mac_pkg::cmd_flags_t             q_flags,
  input  logic [PRICE_BITS-1:0]           q_price,
  input  logic [PRICE_BITS-1:0]           q_old_short,
  input  logic [PRICE_BITS-1:0]           q_old_long,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      signal
);
  import mac_pkg::*;

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + AW;
  localparam int PROD_W = SUM_W + WIN_W;

  logic [SUM_W-1:0]     short_sum, long_sum;
  logic [SUM_W-1:0]     drop_short, drop_long;
  logic                 v1, v2;
  logic                 b1_armed, b1_eval, b2_armed, b2_eval;
  logic [PROD_W-1:0]    prod_short, prod_long;
  rel_t                 prev_rel, rel;
  sig_t                 res_sig;
  logic                 res_push;
  logic [OUT_CNT_W-1:0] out_count;
  logic [OUT_CNT_W+1:0] in_flight;

  // pop only with a result slot guaranteed for every beat in flight
  assign in_flight = (OUT_CNT_W+2)'(out_count) + (OUT_CNT_W+2)'(v1) + (OUT_CNT_W+2)'(v2);
  assign q_pop     = !q_empty && (in_flight < (OUT_CNT_W+2)'(OUT_DEPTH));

  assign drop_short = q_flags.sub_short ? SUM_W'(q_old_short) : '0;
  assign drop_long  = q_flags.sub_long  ? SUM_W'(q_old_long)  : '0;

  // stage 1: running sums
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      short_sum <= '0;
      long_sum  <= '0;
    end else if (q_pop) begin
      short_sum <= short_sum + SUM_W'(q_price) - drop_short;
      long_sum  <= long_sum + SUM_W'(q_price) - drop_long;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
    end
  end

  // flag pipeline
  always_ff @(posedge clk) begin
    b1_armed <= q_flags.armed;
    b1_eval  <= q_flags.eval;
    b2_armed <= b1_armed;
    b2_eval  <= b1_eval;
  end

  // stage 2: cross products, short_sum*L against long_sum*S
  always_ff @(posedge clk) begin
    prod_short <= PROD_W'(short_sum) * PROD_W'(long_win);
    prod_long  <= PROD_W'(long_sum) * PROD_W'(short_win);
  end

  // stage 3: compare and cross detection
  always_comb begin
    if (prod_short > prod_long) begin
      rel = REL_ABOVE;
    end else if (prod_short < prod_long) begin
      rel = REL_BELOW;
    end else begin
      rel = REL_EQUAL;
    end
    res_sig = SIG_NONE;
    if (b2_armed) begin
      if (prev_rel != REL_ABOVE && rel == REL_ABOVE) begin
        res_sig = SIG_BUY;
      end else if (prev_rel != REL_BELOW && rel == REL_BELOW) begin
        res_sig = SIG_SELL;
      end
    end
  end

  assign res_push = v2;

  // relation history
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      prev_rel <= REL_EQUAL;
    end else if (v2 && b2_eval) begin
      prev_rel <= rel;
    end
  end

  // result queue; a pop counts only while a beat is waiting
  mac_queue #(
    .WIDTH (2),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_sig),
    .pop   (pop && !empty),
    .dout  (signal),
    .empty (empty),
    .count (out_count)
  );

  // checks
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_count != OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_buy_needs_change: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_sig == SIG_BUY) |-> prev_rel != REL_ABOVE)
    else $error("buy reported without a cross");

  a_rel_held: assert property (@(posedge clk) disable iff (rst)
    (v2 && !b2_eval && !restart) |=> $stable(prev_rel))
    else $error("relation recorded during warm-up");

endmodule

[hdl/moving_average_crossover_unit.sv]
// ----------------------------------------------------------------------------
// moving_average_crossover_unit: golden / death cross detector
// Top level: configuration registers, window clamping, front part, command
// queue and back part.
// ----------------------------------------------------------------------------
// Takes one price beat per cycle and returns one signal beat per price (none,
// buy, sell) in order. After acceptance a price passes the ring read and the
// command queue, then sum update, cross multiply and compare, before its
// signal enters the result queue. One beat per cycle is sustained as long as
// results are popped. Window writes restart the history; signals resume after
// long_window+1 new prices. Write configuration only while the unit is idle.
module moving_average_crossover_unit #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mac_pkg::APB_AW-1:0]    paddr,
  input  logic [mac_pkg::APB_DW-1:0]    pwdata,
  output logic [mac_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // price side
  input  logic                          push,
  output logic                          full,
  input  logic [PRICE_BITS-1:0]         price,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    signal
);
  import mac_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int CMD_W = $bits(cmd_flags_t) + 3 * PRICE_BITS;

  logic [CFG_W-1:0]     short_window, long_window;
  logic                 cfg_write;
  reg_idx_t             reg_sel;
  logic [WIN_W-1:0]     short_eff, long_eff;
  logic [CMP_W-1:0]     short_c, long_c;

  logic                 q_push, q_pop, q_empty;
  logic [CMD_CNT_W-1:0] q_count;
  cmd_flags_t           f_flags, b_flags;
  logic [PRICE_BITS-1:0] f_price, f_old_short, f_old_long;
  logic [PRICE_BITS-1:0] b_price, b_old_short, b_old_long;
  logic [CMD_W-1:0]     q_din, q_dout;

  // register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= SHORT_RESET;
      long_window  <= LONG_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SHORT: short_window <= pwdata[CFG_W-1:0];
        REG_LONG:  long_window  <= pwdata[CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHORT: prdata = APB_DW'(short_window);
      REG_LONG:  prdata = APB_DW'(long_window);
      default:   prdata = '0;
    endcase
  end

  // window clamping: zero reads as one, cap at ring depth, short within long
  always_comb begin
    long_c  = CMP_W'(long_window);
    short_c = CMP_W'(short_window);
    if (long_c == '0) begin
      long_c = CMP_W'(1);
    end else if (long_c > CMP_W'(MAX_WINDOW)) begin
      long_c = CMP_W'(MAX_WINDOW);
    end
    if (short_c == '0) begin
      short_c = CMP_W'(1);
    end else if (short_c > CMP_W'(MAX_WINDOW)) begin
      short_c = CMP_W'(MAX_WINDOW);
    end
    if (short_c > long_c) begin
      short_c = long_c;
    end
    long_eff  = long_c[WIN_W-1:0];
    short_eff = short_c[WIN_W-1:0];
  end

  // front part
  mac_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .short_win   (short_eff),
    .long_win    (long_eff),
    .push        (push),
    .price       (price),
    .full        (full),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_flags     (f_flags),
    .q_price     (f_price),
    .q_old_short (f_old_short),
    .q_old_long  (f_old_long)
  );

  // command queue between front and back
  assign q_din = {f_flags, f_price, f_old_short, f_old_long};
  assign {b_flags, b_price, b_old_short, b_old_long} = q_dout;

  mac_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  // back part
  mac_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .short_win   (short_eff),
    .long_win    (long_eff),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_flags     (b_flags),
    .q_price     (b_price),
    .q_old_short (b_old_short),
    .q_old_long  (b_old_long),
    .empty       (empty),
    .pop         (pop),
    .signal      (signal)
  );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the moving-average crossover unit
// Streams closing prices through the unit over a series of window settings
// written on the APB port. A local copy of the running sums and relation
// history predicts the signal beat for every price, and the monitor checks
// each popped beat against the oldest prediction. Both the price side and
// the result side stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mac_pkg::*;

  localparam int WIN_MAX     = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1550;

  // price sequence for the first directed window setting (short 1, long 2)
  localparam logic [31:0] CROSS_PRICES [14] = '{
    32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'd1, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 push = 1'b0;
  logic                 full;
  logic [31:0]          price = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [1:0]           signal;

  // prices waiting to be sent, signals waiting to be popped
  logic [31:0] price_backlog[$];
  sig_t        signal_due[$];

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          n_sent = 0;

  // price walk used by the random part
  logic [31:0] walk_lvl = '0;
  logic        walk_up = 1'b1;
  int unsigned walk_span = 1000;

  // predictor state
  logic [8:0]  cfg_short = SHORT_RESET;
  logic [8:0]  cfg_long = LONG_RESET;
  logic [31:0] hist_mem [WIN_MAX];
  logic [7:0]  wr_ptr = '0;
  logic [39:0] sum_s = '0;
  logic [39:0] sum_l = '0;
  logic [8:0]  n_seen = '0;
  rel_t        last_rel = REL_EQUAL;

  moving_average_crossover_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .full    (full),
    .price   (price),
    .empty   (empty),
    .pop     (pop),
    .signal  (signal)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // zero is used as one, anything past the ring depth as the ring depth
  function automatic int unsigned eff_window(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return v;
  endfunction

  function automatic void restart_history();
    wr_ptr = '0;
    sum_s = '0;
    sum_l = '0;
    n_seen = '0;
    last_rel = REL_EQUAL;
  endfunction

  // advance the running sums by one price and return the signal it causes
  function automatic sig_t cross_signal(input logic [31:0] p);
    int unsigned lw;
    int unsigned sw;
    logic [8:0]  prior;
    logic [7:0]  idx;
    logic [63:0] lhs;
    logic [63:0] rhs;
    rel_t        rel;
    sig_t        sig;
    lw = eff_window(cfg_long);
    sw = eff_window(cfg_short);
    if (sw > lw) sw = lw;
    prior = n_seen;
    sig = SIG_NONE;

    sum_s = sum_s + p;
    if (prior >= sw) begin
      idx = wr_ptr - 8'(sw);
      sum_s = sum_s - hist_mem[idx];
    end
    sum_l = sum_l + p;
    if (prior >= lw) begin
      idx = wr_ptr - 8'(lw);
      sum_l = sum_l - hist_mem[idx];
    end
    hist_mem[wr_ptr] = p;
    wr_ptr = wr_ptr + 8'd1;
    if (prior < lw + 1) n_seen = prior + 9'd1;

    // compare averages by cross multiplication
    if (n_seen >= lw) begin
      lhs = 64'(sum_s) * 64'(lw);
      rhs = 64'(sum_l) * 64'(sw);
      if (lhs > rhs) rel = REL_ABOVE;
      else if (lhs < rhs) rel = REL_BELOW;
      else rel = REL_EQUAL;
      if (prior >= lw) begin
        if (last_rel != REL_ABOVE && rel == REL_ABOVE) sig = SIG_BUY;
        else if (last_rel != REL_BELOW && rel == REL_BELOW) sig = SIG_SELL;
      end
      last_rel = rel;
    end
    return sig;
  endfunction

  // trending walk with jumps, flat runs and rail values
  function automatic logic [31:0] gen_price();
    int unsigned r;
    logic [31:0] step;
    r = $urandom_range(0, 99);
    step = $urandom_range(0, walk_span);
    if ($urandom_range(0, 99) < 6) walk_up = !walk_up;
    if (r < 5) walk_lvl = $urandom();
    else if (r < 8) return 32'd0;
    else if (r < 11) return 32'hFFFF_FFFF;
    else if (r < 20) return walk_lvl;
    else if (walk_up ? (r < 75) : (r < 45))
      walk_lvl = (walk_lvl > ~step) ? 32'hFFFF_FFFF : walk_lvl + step;
    else
      walk_lvl = (walk_lvl < step) ? 32'd0 : walk_lvl - step;
    return walk_lvl;
  endfunction

  task automatic queue_prices(input int n);
    repeat (n) price_backlog.push_back(gen_price());
    n_sent += n;
  endtask

  task automatic wait_drained();
    while (price_backlog.size() != 0 || signal_due.size() != 0) @(negedge clk);
  endtask

  // APB write: setup then access; predictor follows at the write edge
  task automatic write_window(input reg_idx_t which, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_SHORT) cfg_short = val[8:0];
    else cfg_long = val[8:0];
    restart_history();
  endtask

  // let the pipe empty, then change both windows
  task automatic set_windows(input logic [8:0] sv, input logic [8:0] lv);
    logic [31:0] junk;
    wait_drained();
    repeat (8) @(posedge clk);
    junk = $urandom();
    write_window(REG_SHORT, {junk[31:9], sv});
    junk = $urandom();
    write_window(REG_LONG, {junk[31:9], lv});
  endtask

  // price driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        signal_due.push_back(cross_signal(price));
        void'(price_backlog.pop_front());
      end
      if (!push || !full) begin
        if (price_backlog.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          push <= 1'b1;
          price <= price_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // signal monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (signal_due.size() == 0) begin
          $error("signal beat %0d popped with nothing expected", signal);
          fail_cnt++;
        end else begin
          sig_t want;
          want = signal_due.pop_front();
          if (signal !== want) begin
            $error("signal mismatch: expected %0d actual %0d", want, signal);
            fail_cnt++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int          n_items;
    int unsigned lw_eff;
    logic [8:0]  sv;
    logic [8:0]  lv;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset windows, no stalls on either side
    walk_lvl = 32'd5_000_000;
    queue_prices(150);
    wait_drained();
    in_idle_pct = 14;
    out_idle_pct = 14;

    // directed: buy, sell and equal around the price rails
    set_windows(9'd1, 9'd2);
    foreach (CROSS_PRICES[i]) price_backlog.push_back(CROSS_PRICES[i]);
    // out-of-range values: short above max, long zero
    set_windows(9'd511, 9'd0);
    price_backlog.push_back(32'hFFFF_FFFF);
    price_backlog.push_back(32'd0);
    price_backlog.push_back(32'hFFFF_FFFF);
    price_backlog.push_back(32'd0);
    // short longer than long gets clamped
    set_windows(9'd5, 9'd3);
    price_backlog.push_back(32'd10);
    price_backlog.push_back(32'd20);
    price_backlog.push_back(32'd30);
    price_backlog.push_back(32'd40);
    price_backlog.push_back(32'd5);
    price_backlog.push_back(32'hFFFF_FFFF);

    // random phases over a spread of window settings
    for (int k = 0; n_sent < ITEM_TARGET; k++) begin
      case (k)
        0: begin
          sv = 9'd1;
          lv = 9'd256;
        end
        1: begin
          sv = 9'd200;
          lv = 9'd511;
        end
        2: begin
          sv = 9'd3;
          lv = 9'd10;
        end
        default: begin
          sv = $urandom_range(0, 24);
          lv = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(49, 300))
                                           : 9'($urandom_range(0, 48));
        end
      endcase
      set_windows(sv, lv);
      case ($urandom_range(0, 2))
        0: walk_span = 3;
        1: walk_span = 2000;
        default: walk_span = 1 << 24;
      endcase
      walk_lvl = $urandom();
      lw_eff = eff_window(lv);
      n_items = lw_eff + 1 + $urandom_range(40, 160);
      if (k == 2) begin
        // hold the sender until every signal is back, then resume
        queue_prices(n_items / 2);
        wait_drained();
        queue_prices(n_items - n_items / 2);
      end else begin
        queue_prices(n_items);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
